[hw/rtl/fde_pkg.sv]
// fde_pkg: shared types, constants and codes of the framebuffer draw engine
// used by fde_ctrl, fde_dp and the top level, depends on nothing
package fde_pkg;

  localparam int FB_WORDS   = 65536;
  localparam int ADDR_W     = $clog2(FB_WORDS);
  localparam int MAX_DIM    = 256;
  localparam int COORD_B    = $clog2(MAX_DIM);
  localparam int CFG_W      = 9;
  localparam int FIELD_W    = 12;
  localparam int COLOR_W    = 32;
  localparam int CO_W       = FIELD_W + 1;
  localparam int PROD_W     = COORD_B + CFG_W + 1;
  localparam int ACALC_W    = (PROD_W > ADDR_W + 1) ? PROD_W : ADDR_W + 1;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam int BAND_COUNT  = 15;
  localparam int BAND_STEP   = 17;
  localparam int GREEN_SHIFT = 8;
  // floor(h / 15) as (h * 2185) >> 15, exact for h up to 1024
  localparam int BAND_RECIP  = 2185;
  localparam int BAND_RSH    = 15;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH  = 2'd2;

  typedef enum logic [2:0] {
    CMD_PIXEL  = 3'd0,
    CMD_RECT   = 3'd1,
    CMD_FILL   = 3'd2,
    CMD_SCROLL = 3'd3,
    CMD_GRAD   = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e_t;

  typedef enum logic [2:0] {
    AS_CLEAR  = 3'd0,
    AS_PLOT   = 3'd1,
    AS_HTOP   = 3'd2,
    AS_HBOT   = 3'd3,
    AS_VLEFT  = 3'd4,
    AS_VRIGHT = 3'd5,
    AS_AREA   = 3'd6,
    AS_SRC    = 3'd7
  } addr_sel_t;

  typedef enum logic [2:0] {
    SRC_ZERO  = 3'd0,
    SRC_COLOR = 3'd1,
    SRC_GRAD  = 3'd2,
    SRC_COPY  = 3'd3,
    SRC_AREA  = 3'd4
  } src_sel_t;

  typedef enum logic [1:0] {
    RNG_SCREEN = 2'd0,
    RNG_COPY   = 2'd1,
    RNG_TAIL   = 2'd2
  } range_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic [FIELD_W-1:0] rect_width;
    logic [FIELD_W-1:0] rect_height;
    logic [COLOR_W-1:0] pixel_color;
    logic [FIELD_W-1:0] scroll_rows;
    logic [FIELD_W-1:0] margin_rows;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_data;
    logic               read_valid;
  } out_item_t;

  typedef struct packed {
    logic      load;
    logic      clr_step;
    logic      wr_en;
    logic      rd_en;
    addr_sel_t addr_sel;
    src_sel_t  src_sel;
    logic      area_init;
    src_sel_t  area_src;
    range_t    area_rng;
    logic      area_step;
    logic      i_clr;
    logic      i_inc;
    logic      res_load;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e_t cmd;
    logic   rect_empty;
    logic   scroll_none;
    logic   scroll_full;
    logic   clear_last;
    logic   h_more;
    logic   v_more;
    logic   area_empty;
    logic   area_last;
    logic   out_free;
  } dp_stat_t;

endpackage

[hw/rtl/fde_ram.sv]
// fde_ram: generic single write port, single read port ram, registered read
// no dependencies
module fde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/fde_ctrl.sv]
// fde_ctrl: sequencing state machine of the draw engine
// depends on fde_pkg; drives the datapath through dp_cmd_t
module fde_ctrl
  import fde_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t st,
  output dp_cmd_t  c
);

  typedef enum logic [14:0] {
    S_CLEAR    = 15'h0001,
    S_IDLE     = 15'h0002,
    S_DISPATCH = 15'h0004,
    S_PLOT     = 15'h0008,
    S_H0       = 15'h0010,
    S_H1       = 15'h0020,
    S_V0       = 15'h0040,
    S_V1       = 15'h0080,
    S_AREA     = 15'h0100,
    S_CCHK     = 15'h0200,
    S_CRD      = 15'h0400,
    S_CWR      = 15'h0800,
    S_RRD      = 15'h1000,
    S_RWT      = 15'h2000,
    S_DONE     = 15'h4000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    c          = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        c.wr_en    = 1'b1;
        c.addr_sel = AS_CLEAR;
        c.src_sel  = SRC_ZERO;
        c.clr_step = 1'b1;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          c.load     = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.cmd)
          CMD_PIXEL: state_next = S_PLOT;
          CMD_RECT: begin
            c.i_clr    = 1'b1;
            state_next = st.rect_empty ? S_DONE : S_H0;
          end
          CMD_FILL: begin
            c.area_init = 1'b1;
            c.area_rng  = RNG_SCREEN;
            c.area_src  = SRC_COLOR;
            state_next  = S_AREA;
          end
          CMD_SCROLL: begin
            if (st.scroll_none) begin
              state_next = S_DONE;
            end else if (st.scroll_full) begin
              c.area_init = 1'b1;
              c.area_rng  = RNG_SCREEN;
              c.area_src  = SRC_ZERO;
              state_next  = S_AREA;
            end else begin
              c.area_init = 1'b1;
              c.area_rng  = RNG_COPY;
              c.area_src  = SRC_COPY;
              state_next  = S_CCHK;
            end
          end
          CMD_GRAD: begin
            c.area_init = 1'b1;
            c.area_rng  = RNG_SCREEN;
            c.area_src  = SRC_GRAD;
            state_next  = S_AREA;
          end
          CMD_READ: state_next = S_RRD;
          default:  state_next = S_DONE;
        endcase
      end
      S_PLOT: begin
        c.wr_en    = 1'b1;
        c.addr_sel = AS_PLOT;
        c.src_sel  = SRC_COLOR;
        state_next = S_DONE;
      end
      S_H0: begin
        if (st.h_more) begin
          c.wr_en    = 1'b1;
          c.addr_sel = AS_HTOP;
          c.src_sel  = SRC_COLOR;
          state_next = S_H1;
        end else begin
          c.i_clr    = 1'b1;
          state_next = S_V0;
        end
      end
      S_H1: begin
        c.wr_en    = 1'b1;
        c.addr_sel = AS_HBOT;
        c.src_sel  = SRC_COLOR;
        c.i_inc    = 1'b1;
        state_next = S_H0;
      end
      S_V0: begin
        if (st.v_more) begin
          c.wr_en    = 1'b1;
          c.addr_sel = AS_VLEFT;
          c.src_sel  = SRC_COLOR;
          state_next = S_V1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_V1: begin
        c.wr_en    = 1'b1;
        c.addr_sel = AS_VRIGHT;
        c.src_sel  = SRC_COLOR;
        c.i_inc    = 1'b1;
        state_next = S_V0;
      end
      S_AREA: begin
        if (st.area_empty) begin
          state_next = S_DONE;
        end else begin
          c.wr_en     = 1'b1;
          c.addr_sel  = AS_AREA;
          c.src_sel   = SRC_AREA;
          c.area_step = 1'b1;
          if (st.area_last) state_next = S_DONE;
        end
      end
      S_CCHK: begin
        if (st.area_empty) begin
          c.area_init = 1'b1;
          c.area_rng  = RNG_TAIL;
          c.area_src  = SRC_ZERO;
          state_next  = S_AREA;
        end else begin
          state_next = S_CRD;
        end
      end
      S_CRD: begin
        c.rd_en    = 1'b1;
        c.addr_sel = AS_SRC;
        state_next = S_CWR;
      end
      S_CWR: begin
        c.wr_en     = 1'b1;
        c.addr_sel  = AS_AREA;
        c.src_sel   = SRC_COPY;
        c.area_step = 1'b1;
        if (st.area_last) begin
          c.area_init = 1'b1;
          c.area_rng  = RNG_TAIL;
          c.area_src  = SRC_ZERO;
          state_next  = S_AREA;
        end else begin
          state_next = S_CRD;
        end
      end
      S_RRD: begin
        c.rd_en    = 1'b1;
        c.addr_sel = AS_PLOT;
        state_next = S_RWT;
      end
      S_RWT: begin
        c.res_load = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          c.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

[hw/rtl/fde_dp.sv]
// fde_dp: datapath of the draw engine: registers, counters, address unit,
// frame store and result register; depends on fde_pkg and fde_ram
module fde_dp
  import fde_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  in_item_t             in_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  dp_cmd_t              c,
  output dp_stat_t             st,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item
);

  logic [CFG_W-1:0]   cfg_w, cfg_h, cfg_p;
  in_item_t           itm;
  logic [FIELD_W-1:0] i_cnt;
  logic [CO_W-1:0]    xc, yc, y_end, bcnt, q;
  src_sel_t           area_src;
  logic [ADDR_W-1:0]  clr_cnt;
  logic               rd_ok, rd_pos;
  out_item_t          res;

  logic [CO_W-1:0]    wv, hv, cx, cy, sm, copy_rows, clear_end, band;
  logic [31:0]        bprod;
  logic [ACALC_W-1:0] addr;
  logic               pos_ok, addr_ok, we;
  logic [ADDR_W-1:0]  waddr;
  logic [COLOR_W-1:0] wdata, rdata, grad;
  src_sel_t           src_eff;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= CFG_RESET;
      cfg_h <= CFG_RESET;
      cfg_p <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  cfg_w <= cfg_data;
        REG_HEIGHT: cfg_h <= cfg_data;
        REG_PITCH:  cfg_p <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wv = (CO_W'(cfg_w) > CO_W'(MAX_DIM)) ? CO_W'(MAX_DIM) : CO_W'(cfg_w);
  assign hv = (CO_W'(cfg_h) > CO_W'(MAX_DIM)) ? CO_W'(MAX_DIM) : CO_W'(cfg_h);

  // band height for gradient, floor(h / 15) and never zero
  assign bprod = 32'(hv) * 32'(BAND_RECIP);
  assign band  = (CO_W'(bprod >> BAND_RSH) == '0) ? CO_W'(1) : CO_W'(bprod >> BAND_RSH);
  assign grad  = (32'(q) * 32'(BAND_STEP)) << GREEN_SHIFT;

  // scroll row counts, clamped at zero
  assign sm        = CO_W'(itm.scroll_rows) + CO_W'(itm.margin_rows);
  assign copy_rows = (sm >= hv) ? '0 : hv - sm;
  assign clear_end = (CO_W'(itm.margin_rows) >= hv) ? '0 : hv - CO_W'(itm.margin_rows);

  // coordinate selection
  always_comb begin
    cx = CO_W'(itm.pos_x);
    cy = CO_W'(itm.pos_y);
    case (c.addr_sel)
      AS_HTOP:   cx = CO_W'(itm.pos_x) + CO_W'(i_cnt);
      AS_HBOT: begin
        cx = CO_W'(itm.pos_x) + CO_W'(i_cnt);
        cy = CO_W'(itm.pos_y) + CO_W'(itm.rect_height) - CO_W'(1);
      end
      AS_VLEFT:  cy = CO_W'(itm.pos_y) + CO_W'(i_cnt);
      AS_VRIGHT: begin
        cx = CO_W'(itm.pos_x) + CO_W'(itm.rect_width) - CO_W'(1);
        cy = CO_W'(itm.pos_y) + CO_W'(i_cnt);
      end
      AS_AREA: begin
        cx = xc;
        cy = yc;
      end
      AS_SRC: begin
        cx = xc;
        cy = yc + CO_W'(itm.scroll_rows);
      end
      default: ;
    endcase
  end

  assign pos_ok  = (cx < wv) && (cy < hv);
  assign addr    = ACALC_W'(cy[COORD_B-1:0] * cfg_p) + ACALC_W'(cx[COORD_B-1:0]);
  assign addr_ok = addr < ACALC_W'(FB_WORDS);

  assign src_eff = (c.src_sel == SRC_AREA) ? area_src : c.src_sel;
  always_comb begin
    case (src_eff)
      SRC_COLOR: wdata = itm.pixel_color;
      SRC_GRAD:  wdata = grad;
      SRC_COPY:  wdata = rd_ok ? rdata : '0;
      default:   wdata = '0;
    endcase
  end

  assign we    = c.wr_en && ((c.addr_sel == AS_CLEAR) || (pos_ok && addr_ok));
  assign waddr = (c.addr_sel == AS_CLEAR) ? clr_cnt : addr[ADDR_W-1:0];

  fde_ram #(.WIDTH(COLOR_W), .DEPTH(FB_WORDS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (c.rd_en),
    .raddr (addr[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (c.clr_step) clr_cnt <= clr_cnt + ADDR_W'(1);
      if (c.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload, walker, read flag and result registers
  always_ff @(posedge clk) begin
    if (c.load) begin
      itm <= in_item;
      res <= '0;
    end
    if (c.i_clr) begin
      i_cnt <= '0;
    end else if (c.i_inc) begin
      i_cnt <= i_cnt + FIELD_W'(1);
    end
    if (c.area_init) begin
      area_src <= c.area_src;
      xc       <= '0;
      bcnt     <= '0;
      q        <= '0;
      case (c.area_rng)
        RNG_COPY: begin
          yc    <= '0;
          y_end <= copy_rows;
        end
        RNG_TAIL: begin
          yc    <= copy_rows;
          y_end <= clear_end;
        end
        default: begin
          yc    <= '0;
          y_end <= hv;
        end
      endcase
    end else if (c.area_step) begin
      if (xc == wv - CO_W'(1)) begin
        xc <= '0;
        yc <= yc + CO_W'(1);
        if (bcnt == band - CO_W'(1)) begin
          bcnt <= '0;
          q    <= q + CO_W'(1);
        end else begin
          bcnt <= bcnt + CO_W'(1);
        end
      end else begin
        xc <= xc + CO_W'(1);
      end
    end
    if (c.rd_en) begin
      rd_ok  <= pos_ok && addr_ok;
      rd_pos <= pos_ok;
    end
    if (c.res_load) begin
      res.read_data  <= rd_ok ? rdata : '0;
      res.read_valid <= rd_pos;
    end
    if (c.out_load) out_item <= res;
  end

  assign st.cmd         = cmd_e_t'(itm.cmd);
  assign st.rect_empty  = (itm.rect_width == '0) || (itm.rect_height == '0);
  assign st.scroll_none = (itm.scroll_rows == '0);
  assign st.scroll_full = (CO_W'(itm.scroll_rows) >= hv);
  assign st.clear_last  = (clr_cnt == ADDR_W'(FB_WORDS - 1));
  assign st.h_more      = (i_cnt < itm.rect_width) &&
                          (CO_W'(itm.pos_x) + CO_W'(i_cnt) < wv);
  assign st.v_more      = (i_cnt < itm.rect_height) &&
                          (CO_W'(itm.pos_y) + CO_W'(i_cnt) < hv);
  assign st.area_empty  = (yc >= y_end) || (wv == '0);
  assign st.area_last   = (xc == wv - CO_W'(1)) && (yc == y_end - CO_W'(1));
  assign st.out_free    = !out_valid || !out_stall;

endmodule

[hw/rtl/framebuffer_draw_engine.sv]
// framebuffer_draw_engine: top level, one drawing command per item, one result per item
// after reset a clearing pass zeroes all 65536 words, items are held off
// pixel goes through S_PLOT, read through S_RRD and S_RWT; outline writes edge pixel pairs
// (S_H0, S_H1 top and bottom, then S_V0, S_V1 left and right); fill and gradient walk the
// screen, one store write per cycle; scroll copy reads then writes the store per pixel
// depends on fde_pkg, fde_ctrl, fde_dp, fde_ram; reset is synchronous, active high
module framebuffer_draw_engine
  import fde_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // controller: one item at a time, the result waits in the output register
  fde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (dp_stat),
    .c        (dp_cmd)
  );

  // datapath: frame store, pixel walker, address unit and result register
  fde_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .c         (dp_cmd),
    .st        (dp_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // an accepted item keeps the input side held off in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while busy");

  // the store never reads and writes in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    !(dp_cmd.wr_en && dp_cmd.rd_en))
    else $error("store read and write collide");

  // a new result only appears at the end of an item's work
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without item");

endmodule

[sim/fde_checker.sv]
// fde_checker: watches the item channels and register writes of the draw engine,
// keeps its own frame store, predicts each result and compares; depends on fde_pkg
module fde_checker
  import fde_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending
);

  logic [COLOR_W-1:0] pix_mem [FB_WORDS];
  int unsigned        scr_w, scr_h, pitch_r;
  out_item_t          read_q[$];

  function automatic int unsigned vis_w();
    return (scr_w > MAX_DIM) ? MAX_DIM : scr_w;
  endfunction

  function automatic int unsigned vis_h();
    return (scr_h > MAX_DIM) ? MAX_DIM : scr_h;
  endfunction

  function automatic void mem_put(int unsigned x, int unsigned y, logic [31:0] v);
    longint unsigned a;
    a = longint'(y) * pitch_r + x;
    if (a < FB_WORDS) pix_mem[a] = v;
  endfunction

  function automatic logic [31:0] mem_get(int unsigned x, int unsigned y);
    longint unsigned a;
    a = longint'(y) * pitch_r + x;
    return (a < FB_WORDS) ? pix_mem[a] : 32'd0;
  endfunction

  function automatic void plot(int unsigned x, int unsigned y, logic [31:0] c);
    if (x < vis_w() && y < vis_h()) mem_put(x, y, c);
  endfunction

  function automatic void paint_rows(int unsigned y0, int unsigned y1, logic [31:0] c);
    for (int unsigned y = y0; y < y1; y++)
      for (int unsigned x = 0; x < vis_w(); x++) mem_put(x, y, c);
  endfunction

  // apply one drawing command to the store and give the read-back it produces
  function automatic out_item_t draw_item(in_item_t it);
    out_item_t   r;
    int unsigned x, y, w, h, s, m, nh, copy_n, clr_end, band;
    logic [31:0] c;
    r = '0;
    x = 32'(it.pos_x); y = 32'(it.pos_y);
    w = 32'(it.rect_width); h = 32'(it.rect_height);
    s = 32'(it.scroll_rows); m = 32'(it.margin_rows); c = it.pixel_color;
    nh = vis_h();
    case (it.cmd)
      CMD_PIXEL: plot(x, y, c);
      CMD_RECT: begin
        if (w != 0 && h != 0) begin
          for (int unsigned i = 0; i < w && x + i < vis_w(); i++) begin
            plot(x + i, y, c);
            plot(x + i, y + h - 1, c);
          end
          for (int unsigned i = 0; i < h && y + i < nh; i++) begin
            plot(x, y + i, c);
            plot(x + w - 1, y + i, c);
          end
        end
      end
      CMD_FILL: paint_rows(0, nh, c);
      CMD_SCROLL: begin
        if (s != 0) begin
          if (s >= nh) paint_rows(0, nh, 32'd0);
          else begin
            copy_n  = (s + m >= nh) ? 0 : nh - s - m;
            clr_end = (m >= nh) ? 0 : nh - m;
            // in-place copy, ascending rows then columns
            for (int unsigned yy = 0; yy < copy_n; yy++)
              for (int unsigned xx = 0; xx < vis_w(); xx++)
                mem_put(xx, yy, mem_get(xx, yy + s));
            paint_rows(copy_n, clr_end, 32'd0);
          end
        end
      end
      CMD_GRAD: begin
        band = nh / BAND_COUNT;
        if (band == 0) band = 1;
        for (int unsigned yy = 0; yy < nh; yy++)
          paint_rows(yy, yy + 1, ((yy / band) * BAND_STEP) << GREEN_SHIFT);
      end
      CMD_READ: begin
        if (x < vis_w() && y < nh) begin
          r.read_data  = mem_get(x, y);
          r.read_valid = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      foreach (pix_mem[i]) pix_mem[i] = '0;
      scr_w   = 32'(CFG_RESET);
      scr_h   = 32'(CFG_RESET);
      pitch_r = 32'(CFG_RESET);
      errors  = 0;
      read_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  scr_w   = 32'(cfg_data);
          REG_HEIGHT: scr_h   = 32'(cfg_data);
          REG_PITCH:  pitch_r = 32'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) read_q.push_back(draw_item(in_item));
      if (out_valid && !out_stall) begin
        if (read_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item read_data=%h read_valid=%b", $time,
                   out_item.read_data, out_item.read_valid);
        end else begin
          want = read_q.pop_front();
          if (want.read_data !== out_item.read_data) begin
            errors++;
            $display("%0t: read_data expected %h actual %h", $time,
                     want.read_data, out_item.read_data);
          end
          if (want.read_valid !== out_item.read_valid) begin
            errors++;
            $display("%0t: read_valid expected %b actual %b", $time,
                     want.read_valid, out_item.read_valid);
          end
        end
      end
    end
    pending = read_q.size();
  end

endmodule

[sim/tb.sv]
// tb: stimulus and verdict for framebuffer_draw_engine
// depends on fde_pkg, the engine rtl and fde_checker
module tb;
  import fde_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind it
  localparam int CYCLE_LIMIT = 10000000;
  localparam int HOLD_CYCLES = 400;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int errors, pending;
  int cycles = 0;
  bit quiet = 1'b0;      // no idling on either side while set
  bit hold_req = 1'b0;   // asks the receiver for a long hold-off
  bit hold_done = 1'b0;  // the long hold-off has been served
  int unsigned cur_w = 256, cur_h = 256;

  framebuffer_draw_engine uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fde_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("framebuffer_draw_engine verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < 9);
    end
  end

  function automatic in_item_t mk(cmd_e_t c, int x, int y, int w, int h,
                                  logic [31:0] col, int s, int m);
    in_item_t it;
    it.cmd = c;
    it.pos_x = FIELD_W'(x); it.pos_y = FIELD_W'(y);
    it.rect_width = FIELD_W'(w); it.rect_height = FIELD_W'(h);
    it.pixel_color = col;
    it.scroll_rows = FIELD_W'(s); it.margin_rows = FIELD_W'(m);
    return it;
  endfunction

  // offer one item and hold it until accepted; called at a rising edge
  task automatic send(in_item_t it);
    in_item  <= it;
    in_valid <= 1'b1;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    if (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // wait for every result, then let the engine finish any store work
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_cfg(int unsigned w, int unsigned h, int unsigned p);
    cfg_we <= 1'b1; cfg_index <= REG_SPARE; cfg_data <= CFG_W'($urandom);
    @(posedge clk);
    cfg_index <= REG_WIDTH;  cfg_data <= CFG_W'(w); @(posedge clk);
    cfg_index <= REG_HEIGHT; cfg_data <= CFG_W'(h); @(posedge clk);
    cfg_index <= REG_PITCH;  cfg_data <= CFG_W'(p); @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = (w > MAX_DIM) ? MAX_DIM : w;
    cur_h = (h > MAX_DIM) ? MAX_DIM : h;
    @(posedge clk);
  endtask

  // mostly in-screen coordinates, sometimes the whole 12-bit range
  function automatic int coord(int unsigned lim);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 4095);
    return $urandom_range(0, lim + 2);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned pick;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.pos_x = FIELD_W'(coord(cur_w));
    it.pos_y = FIELD_W'(coord(cur_h));
    it.rect_width  = FIELD_W'(coord(cur_w));
    it.rect_height = FIELD_W'(coord(cur_h));
    it.scroll_rows = ($urandom_range(0, 7) == 0) ? FIELD_W'($urandom_range(0, 4095))
                                                 : FIELD_W'($urandom_range(0, cur_h + 1));
    it.margin_rows = ($urandom_range(0, 7) == 0) ? FIELD_W'($urandom_range(0, 4095))
                                                 : FIELD_W'($urandom_range(0, 4));
    pick = $urandom_range(0, 99);
    // reads dominate so that stored contents get checked
    if (pick < 25)      it.cmd = CMD_PIXEL;
    else if (pick < 40) it.cmd = CMD_RECT;
    else if (pick < 44) it.cmd = CMD_FILL;
    else if (pick < 50) it.cmd = CMD_SCROLL;
    else if (pick < 53) it.cmd = CMD_GRAD;
    else if (pick < 96) it.cmd = CMD_READ;
    else                it.cmd = 3'($urandom_range(6, 7));
    return it;
  endfunction

  task automatic rand_burst(int n);
    repeat (n) send(rand_item());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full-size screen at reset settings: corners, clipping, every command
    send(mk(CMD_PIXEL, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0));
    send(mk(CMD_PIXEL, 255, 255, 0, 0, 32'h1234_5678, 0, 0));
    send(mk(CMD_PIXEL, 256, 0, 0, 0, 32'hDEAD_BEEF, 0, 0));
    send(mk(CMD_PIXEL, 4095, 4095, 0, 0, 32'hDEAD_BEEF, 0, 0));
    send(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_READ, 255, 255, 0, 0, 0, 0, 0));
    send(mk(CMD_READ, 256, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_READ, 0, 256, 0, 0, 0, 0, 0));
    send(mk(CMD_RECT, 250, 250, 20, 20, 32'hA5A5_5A5A, 0, 0));
    send(mk(CMD_RECT, 10, 10, 0, 5, 32'h1, 0, 0));
    send(mk(CMD_RECT, 10, 10, 5, 0, 32'h1, 0, 0));
    send(mk(CMD_RECT, 4095, 4095, 4095, 4095, 32'h2, 0, 0));
    send(mk(CMD_READ, 250, 255, 0, 0, 0, 0, 0));
    send(mk(cmd_e_t'(3'd6), 1, 1, 1, 1, 32'h3, 1, 1));
    send(mk(cmd_e_t'(3'd7), 1, 1, 1, 1, 32'h3, 1, 1));
    send(mk(CMD_FILL, 0, 0, 0, 0, 32'h00C0_FFEE, 0, 0));
    send(mk(CMD_READ, 17, 99, 0, 0, 0, 0, 0));
    send(mk(CMD_GRAD, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_READ, 0, 255, 0, 0, 0, 0, 0));
    send(mk(CMD_SCROLL, 0, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_SCROLL, 0, 0, 0, 0, 0, 3, 2));
    send(mk(CMD_READ, 0, 251, 0, 0, 0, 0, 0));
    send(mk(CMD_SCROLL, 0, 0, 0, 0, 0, 4095, 4095));
    send(mk(CMD_READ, 3, 3, 0, 0, 0, 0, 0));
    settle();

    // oversized width, long pitch so the bottom rows fall beyond the store
    write_cfg(300, 200, 511);
    send(mk(CMD_FILL, 0, 0, 0, 0, 32'h5555_AAAA, 0, 0));
    send(mk(CMD_READ, 255, 199, 0, 0, 0, 0, 0));
    send(mk(CMD_SCROLL, 0, 0, 0, 0, 0, 60, 4095));
    rand_burst(12);
    settle();

    // smallest non-empty screen and pitch
    write_cfg(1, 1, 1);
    rand_burst(8);
    settle();

    // zero-width screen draws nothing, then a tall one clamped to 256 rows
    write_cfg(0, 5, 8);
    rand_burst(4);
    settle();
    write_cfg(4, 511, 4);
    rand_burst(6);
    settle();

    // random small screens; one long receiver hold-off, one quiet stretch
    for (int ph = 0; ph < 5; ph++) begin
      write_cfg($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(1, 40));
      if (ph == 1) hold_req = 1'b1;
      quiet = (ph == 3);
      rand_burst(10);
      settle();
    end
    quiet = 1'b0;

    if (errors == 0) begin
      $display("framebuffer_draw_engine verification clean");
    end else begin
      $display("framebuffer_draw_engine verification failed");
    end
    $finish;
  end

endmodule
